@@ sv/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define ABGN_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that stays active during reset
`define ABGN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/abgn_pkg.sv @@
// shared types, codes and helper functions of the bar graph node
package abgn_pkg;

    // request kinds carried in s_tuser
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // ascii codes used by the packet parser
    localparam logic [7:0] CHAR_HASH     = 8'h23;
    localparam logic [7:0] CHAR_AT       = 8'd64;
    localparam logic [7:0] CHAR_LBRACKET = 8'd91;
    localparam logic [7:0] CHAR_SLASH    = 8'd47;
    localparam logic [7:0] CHAR_COLON    = 8'd58;
    localparam logic [7:0] CHAR_ZERO     = 8'd48;

    localparam logic [9:0] ACC_MAX   = 10'd1023;
    localparam logic [9:0] SHOW_MAX  = 10'd100;
    localparam int         LED_COUNT = 10;

    // register reset values
    localparam logic [7:0] OWN_ADDRESS_RST = 8'd65;
    localparam logic [7:0] PWM_PERIOD_RST  = 8'd200;
    localparam logic [6:0] VALUE_LIMIT_RST = 7'd100;
    localparam logic [6:0] OVER_LIMIT_RST  = 7'd90;

    typedef enum logic [1:0] {
        REG_OWN_ADDRESS = 2'd0,
        REG_PWM_PERIOD  = 2'd1,
        REG_VALUE_LIMIT = 2'd2,
        REG_OVER_LIMIT  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] own_address;
        logic [7:0] pwm_period;
        logic [6:0] value_limit;
        logic [6:0] over_limit_value;
    } cfg_t;

    // next-state view handed from the parser to the output stage
    typedef struct packed {
        logic [6:0] display_value;
        logic       partial_lit;
        logic       selected;
    } node_view_t;

    typedef struct packed {
        logic [3:0] full;
        logic [3:0] rem;
    } digits_t;

    // tens and units of a 7 bit value by threshold compares
    function automatic digits_t digits_of(input logic [6:0] value);
        digits_t    d;
        logic [6:0] full7;
        logic [6:0] tens;
        logic [6:0] rem7;
        d.full = 4'd0;
        for (int i = 1; i <= 12; i++) begin
            if (value >= 7'(i * 10)) begin
                d.full = 4'(i);
            end
        end
        full7  = {3'b000, d.full};
        tens   = (full7 << 3) + (full7 << 1);
        rem7   = value - tens;
        d.rem  = rem7[3:0];
        return d;
    endfunction

    // pwm duty for the dimmed led: rem^2*2+1
    function automatic logic [7:0] duty_of(input logic [6:0] value);
        digits_t    d;
        logic [7:0] duty;
        d = digits_of(value);
        case (d.rem)
            4'd0:    duty = 8'd1;
            4'd1:    duty = 8'd3;
            4'd2:    duty = 8'd9;
            4'd3:    duty = 8'd19;
            4'd4:    duty = 8'd33;
            4'd5:    duty = 8'd51;
            4'd6:    duty = 8'd73;
            4'd7:    duty = 8'd99;
            4'd8:    duty = 8'd129;
            4'd9:    duty = 8'd163;
            default: duty = 8'd1;
        endcase
        return duty;
    endfunction

endpackage

@@ sv/abgn_cfg_regs.sv @@
// configuration register file of the bar graph node
module abgn_cfg_regs
    import abgn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_OWN_ADDRESS: cfg_next.own_address      = cfg_data;
                REG_PWM_PERIOD:  cfg_next.pwm_period       = cfg_data;
                REG_VALUE_LIMIT: cfg_next.value_limit      = cfg_data[6:0];
                REG_OVER_LIMIT:  cfg_next.over_limit_value = cfg_data[6:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_address      <= OWN_ADDRESS_RST;
            cfg_reg.pwm_period       <= PWM_PERIOD_RST;
            cfg_reg.value_limit      <= VALUE_LIMIT_RST;
            cfg_reg.over_limit_value <= OVER_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/abgn_state.sv @@
// packet parser, value latch and pwm counter state
module abgn_state
    import abgn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       update,
    input  logic       req_type,
    input  logic [7:0] char_code,
    input  cfg_t       cfg,
    output node_view_t view_next
);

    logic       addressed_reg, addressed_next;
    logic [9:0] acc_reg, acc_next;
    logic [6:0] display_reg, display_next;
    logic [7:0] pwm_count_reg, pwm_count_next;
    logic       partial_reg, partial_next;

    logic        is_own, is_hash, is_cap, is_digit;
    logic        do_settle, take_acc;
    logic [9:0]  settle_val;
    logic [9:0]  acc_base;
    logic [13:0] acc_prod;
    logic [7:0]  cnt_inc;
    logic [7:0]  digit_off;

    always_comb begin
        addressed_next = addressed_reg;
        acc_next       = acc_reg;
        display_next   = display_reg;
        pwm_count_next = pwm_count_reg;
        partial_next   = partial_reg;

        is_own    = (char_code == cfg.own_address);
        is_hash   = (char_code == CHAR_HASH);
        is_cap    = (char_code > CHAR_AT) && (char_code < CHAR_LBRACKET);
        is_digit  = (char_code > CHAR_SLASH) && (char_code < CHAR_COLON);
        digit_off = char_code - CHAR_ZERO;
        do_settle = 1'b0;
        take_acc  = 1'b0;
        cnt_inc   = pwm_count_reg + 8'd1;

        // value picked on select or deselect, with limit and display clamp
        settle_val = 10'd0;
        acc_base   = 10'd0;
        acc_prod   = 14'd0;

        if (req_type == REQ_TICK) begin
            if (cnt_inc == duty_of(display_reg)) begin
                partial_next = 1'b0;
            end
            if (cnt_inc == cfg.pwm_period) begin
                partial_next   = 1'b1;
                pwm_count_next = 8'd0;
            end else begin
                pwm_count_next = cnt_inc;
            end
        end else begin
            // own address wins over the deselect set
            if (is_own) begin
                addressed_next = 1'b1;
                do_settle      = 1'b1;
                take_acc       = (acc_reg != 10'd0);
            end else if (is_hash || is_cap) begin
                addressed_next = 1'b0;
                do_settle      = 1'b1;
                take_acc       = (acc_reg != 10'd0) && is_hash;
            end

            settle_val = take_acc ? acc_reg : {3'b000, display_reg};
            if (settle_val > {3'b000, cfg.value_limit}) begin
                settle_val = {3'b000, cfg.over_limit_value};
            end
            if (settle_val > SHOW_MAX) begin
                settle_val = SHOW_MAX;
            end
            if (do_settle) begin
                display_next = settle_val[6:0];
            end

            acc_base = do_settle ? 10'd0 : acc_reg;
            acc_next = acc_base;
            if (addressed_next && is_digit) begin
                acc_prod = ({4'b0000, acc_base} << 3) + ({4'b0000, acc_base} << 1)
                         + {10'd0, digit_off[3:0]};
                acc_next = (acc_prod > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_prod[9:0];
            end

            partial_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addressed_reg <= 1'b0;
            acc_reg       <= 10'd0;
            display_reg   <= 7'd1;
            pwm_count_reg <= 8'd0;
            partial_reg   <= 1'b0;
        end else if (update) begin
            addressed_reg <= addressed_next;
            acc_reg       <= acc_next;
            display_reg   <= display_next;
            pwm_count_reg <= pwm_count_next;
            partial_reg   <= partial_next;
        end
    end

    assign view_next.display_value = display_next;
    assign view_next.partial_lit   = partial_next;
    assign view_next.selected      = addressed_next;

endmodule

@@ sv/abgn_out_reg.sv @@
// bar pattern encoder and result register
module abgn_out_reg
    import abgn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  node_view_t  view,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [23:0] m_tdata
);

    logic        valid_reg, valid_next;
    logic [23:0] data_reg;
    logic [9:0]  pattern;
    digits_t     d;
    logic [3:0]  full;

    always_comb begin
        d    = digits_of(view.display_value);
        full = (d.full > 4'(LED_COUNT)) ? 4'(LED_COUNT) : d.full;
        for (int i = 0; i < LED_COUNT; i++) begin
            pattern[i] = (4'(i) < full) || ((4'(i) == full) && view.partial_lit);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {6'd0, view.selected, view.display_value, pattern};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

@@ sv/addressed_bar_graph_node.sv @@
// top level of the addressed bar graph node
//
// usage
//   s_ channel: one request per beat, s_tuser selects a received character (0) or a
//   pwm timer tick (1), s_tdata[7:0] carries the character code
//   m_ channel: one result per request, m_tdata holds led_pattern, shown_value and
//   selected as seen right after that request took effect
//   cfg port: write enable, 2 bit register index, 8 bit data; written while idle
// path: an accepted request sits in the input register, its result is loaded into the
//   output register once that register is free, and is offered from then on
// throughput: one request per cycle while the result channel is not stalled; all parsing,
//   latching and pwm work is one shallow combinational pass from input to result register
// reset: synchronous, active low; node deselected, value 1 shown, pwm counter and
//   dimmed led cleared, registers back to their reset values, both channels empty
// stall: while m_tready is low the result waits in the output register, the input
//   register still takes one more request, then s_tready drops until the result moves
module addressed_bar_graph_node
    import abgn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [9:0] led_pattern, [16:10] shown_value, [17] selected
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t       cfg;
    node_view_t view_next;

    logic       in_valid_reg, in_valid_next;
    logic       in_type_reg;
    logic [7:0] in_char_reg;
    logic       out_free;
    logic       advance;
    logic       s_accept;

    // output register can take a result when empty or being drained
    assign out_free = !m_tvalid || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // request payload, held while the output side stalls
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_type_reg <= s_tuser;
            in_char_reg <= s_tdata;
        end
    end

    abgn_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // parser state moves only when its result can be stored
    abgn_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update    (advance),
        .req_type  (in_type_reg),
        .char_code (in_char_reg),
        .cfg       (cfg),
        .view_next (view_next)
    );

    abgn_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .view     (view_next),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

@@ sv/abgn_checker.sv @@
// port level checks of the bar graph node and their bind
`include "assert_macros.svh"

module abgn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result keeps its value
    `ABGN_ASSERT(a_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "result changed while stalled")

    // reset empties the result channel
    `ABGN_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // lit leds always form a solid run from led 0
    `ABGN_ASSERT(a_bar_shape, aclk, aresetn,
        m_tvalid |-> ((m_tdata[9:0] & (m_tdata[9:0] + 10'd1)) == 10'd0),
        "bar pattern has a gap")

    // shown value clamped to full scale
    `ABGN_ASSERT(a_value_range, aclk, aresetn,
        m_tvalid |-> (m_tdata[16:10] <= 7'd100),
        "shown value above full scale")

    // padding bits stay clear
    `ABGN_ASSERT(a_pad_zero, aclk, aresetn,
        m_tvalid |-> (m_tdata[23:18] == 6'd0),
        "result padding not zero")

endmodule

bind addressed_bar_graph_node abgn_checker u_abgn_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
